/* src/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros used by the colormap front end (hsvc_front).
// Define NO_ASSERTIONS to compile every macro to nothing.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every rising edge out of reset
`define ASSERT_IMPL(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("hsvc assertion failed");

// Next-cycle implication, checked on every rising edge out of reset
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("hsvc assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst_n, cond, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

/* src/hsvc_pkg.sv */
// ---------------------------------------------------------------------------
// hsvc_pkg
// Shared constants, codes and stage types of the HSV to RGB colormap unit.
// ---------------------------------------------------------------------------
package hsvc_pkg;

    // Default parameter values
    localparam int DEF_CHANNEL_BITS  = 8;
    localparam int DEF_HUE_FRAC_BITS = 6;

    // Field widths
    localparam int HUE_BITS     = 16;
    localparam int SV_BITS      = 9;
    localparam int SCALE_BITS   = 11;
    localparam int ERR_BITS     = 3;
    localparam int MODE_BITS    = 2;
    localparam int IN_DATA_BITS = 48;

    // Color modes
    localparam logic [MODE_BITS-1:0] MODE_DIRECT    = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_RED_GREEN = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_RAINBOW   = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_GRAY      = 2'd3;

    // Error codes
    localparam logic [ERR_BITS-1:0] ERR_NONE  = 3'd0;
    localparam logic [ERR_BITS-1:0] ERR_SAT   = 3'd1;
    localparam logic [ERR_BITS-1:0] ERR_VAL   = 3'd2;
    localparam logic [ERR_BITS-1:0] ERR_HUE   = 3'd3;
    localparam logic [ERR_BITS-1:0] ERR_SCALE = 3'd4;

    // Hue sectors of 60 degrees
    localparam logic [2:0] SEC_R_TO_Y = 3'd0;
    localparam logic [2:0] SEC_Y_TO_G = 3'd1;
    localparam logic [2:0] SEC_G_TO_C = 3'd2;
    localparam logic [2:0] SEC_C_TO_B = 3'd3;
    localparam logic [2:0] SEC_B_TO_M = 3'd4;
    localparam logic [2:0] SEC_M_TO_R = 3'd5;

    // Internal hue position runs in 1/1024 degree steps; one sector spans
    // 60 * 1024 = 15 * 2^12 steps.
    localparam int HPOS_BITS       = 19;
    localparam int SCALE_FRAC_BITS = 10;
    localparam logic [HPOS_BITS-1:0] SPAN      = 19'd61440;
    localparam logic [HPOS_BITS-1:0] SPAN_AT_1 = 19'd61440;
    localparam logic [HPOS_BITS-1:0] SPAN_AT_2 = 19'd122880;
    localparam logic [HPOS_BITS-1:0] SPAN_AT_3 = 19'd184320;
    localparam logic [HPOS_BITS-1:0] SPAN_AT_4 = 19'd245760;
    localparam logic [HPOS_BITS-1:0] SPAN_AT_5 = 19'd307200;

    // Chroma and offset in 1/65536, ramp up to one span
    localparam int RAMP_BITS = 16;
    localparam int CM_BITS   = 17;
    localparam logic [CM_BITS-1:0] FULL_CHROMA = 17'h10000;

    // Channel sums in 1/(65536 * SPAN) fit 32 bits; the 2^28 part of the
    // divisor is dropped by a shift, the factor 15 by a reciprocal.
    localparam int PROD_BITS   = 32;
    localparam int LEVEL_SHIFT = 28;

    // Front end result handed to the mixing stages
    typedef struct packed {
        logic [2:0]           sector;
        logic [RAMP_BITS-1:0] ramp;
        logic [CM_BITS-1:0]   chroma;
        logic [CM_BITS-1:0]   offset;
        logic [ERR_BITS-1:0]  err;
    } hsvc_front_t;

endpackage

/* src/hsvc_front.sv */
// ---------------------------------------------------------------------------
// hsvc_front
// Stages 1 and 2: mode decode, range checks, chroma and offset, hue
// position, sector and triangular ramp.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hsvc_front
    import hsvc_pkg::*;
#(
    parameter int HUE_FRAC_BITS = DEF_HUE_FRAC_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [HUE_BITS-1:0]   hue,
    input  logic [SV_BITS-1:0]    saturation,
    input  logic [SV_BITS-1:0]    brightness,
    input  logic [SCALE_BITS-1:0] scale_value,
    input  logic [MODE_BITS-1:0]  color_mode,
    output logic                  out_valid,
    input  logic                  out_ready,
    output hsvc_front_t           out_data
);

    localparam int HUE_SHIFT = SCALE_FRAC_BITS - HUE_FRAC_BITS;
    localparam int WIDE_BITS = HUE_BITS + SCALE_FRAC_BITS;
    localparam logic [31:0] HUE_LIMIT = 32'(360 << HUE_FRAC_BITS);
    localparam logic [SV_BITS-1:0]    UNIT_SV    = 9'd256;
    localparam logic [SCALE_BITS-1:0] UNIT_SCALE = 11'd1024;

    // Stage 1 registers
    logic                  s1_valid_reg;
    logic [HPOS_BITS-1:0]  s1_h_reg,   s1_h_next;
    logic [CM_BITS-1:0]    s1_c_reg,   s1_c_next;
    logic [CM_BITS-1:0]    s1_m_reg,   s1_m_next;
    logic [ERR_BITS-1:0]   s1_err_reg, s1_err_next;
    logic                  s1_ready;

    // Stage 2 registers
    logic                  s2_valid_reg;
    hsvc_front_t           s2_data_reg, s2_data_next;
    logic                  s2_ready;

    logic [WIDE_BITS-1:0]  hue_wide;
    logic [2*SV_BITS-1:0]  sv_prod;
    logic [HPOS_BITS-1:0]  base;
    logic [RAMP_BITS-1:0]  pos;

    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s2_ready = !s2_valid_reg || out_ready;
    assign in_ready = s1_ready;

    // Decode mode, check ranges, form hue position, chroma and offset.
    // A failing item carries zero chroma and offset, so it comes out black.
    always_comb
    begin
        hue_wide    = WIDE_BITS'(hue) << HUE_SHIFT;
        sv_prod     = (2*SV_BITS)'(brightness) * (2*SV_BITS)'(saturation);
        s1_h_next   = '0;
        s1_c_next   = '0;
        s1_m_next   = '0;
        s1_err_next = ERR_NONE;
        unique case (color_mode)
            MODE_DIRECT:
            begin
                if (saturation > UNIT_SV)
                begin
                    s1_err_next = ERR_SAT;
                end
                else if (brightness > UNIT_SV)
                begin
                    s1_err_next = ERR_VAL;
                end
                else if (32'(hue) >= HUE_LIMIT)
                begin
                    s1_err_next = ERR_HUE;
                end
                else
                begin
                    s1_h_next = hue_wide[HPOS_BITS-1:0];
                    s1_c_next = sv_prod[CM_BITS-1:0];
                    s1_m_next = {brightness, 8'b0} - sv_prod[CM_BITS-1:0];
                end
            end
            MODE_RED_GREEN:
            begin
                if (scale_value > UNIT_SCALE)
                begin
                    s1_err_next = ERR_SCALE;
                end
                else
                begin
                    s1_h_next = HPOS_BITS'(scale_value) * 19'd120;
                    s1_c_next = FULL_CHROMA;
                end
            end
            MODE_RAINBOW:
            begin
                if (scale_value > UNIT_SCALE)
                begin
                    s1_err_next = ERR_SCALE;
                end
                else
                begin
                    s1_h_next = HPOS_BITS'(scale_value) * 19'd270;
                    s1_c_next = FULL_CHROMA;
                end
            end
            MODE_GRAY:
            begin
                // Gray rides the offset path: scalar/1024 scaled to 1/65536
                if (scale_value > UNIT_SCALE)
                begin
                    s1_err_next = ERR_SCALE;
                end
                else
                begin
                    s1_m_next = CM_BITS'(scale_value) << 6;
                end
            end
            default:
            begin
                s1_err_next = ERR_NONE;
            end
        endcase
    end

    // Advance stage 1 valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // Load stage 1 payload
    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_h_reg   <= s1_h_next;
            s1_c_reg   <= s1_c_next;
            s1_m_reg   <= s1_m_next;
            s1_err_reg <= s1_err_next;
        end
    end

    // Find the sector, the position inside it and the triangular ramp
    always_comb
    begin
        s2_data_next = '0;
        if (s1_h_reg >= SPAN_AT_5)
        begin
            s2_data_next.sector = SEC_M_TO_R;
            base                = SPAN_AT_5;
        end
        else if (s1_h_reg >= SPAN_AT_4)
        begin
            s2_data_next.sector = SEC_B_TO_M;
            base                = SPAN_AT_4;
        end
        else if (s1_h_reg >= SPAN_AT_3)
        begin
            s2_data_next.sector = SEC_C_TO_B;
            base                = SPAN_AT_3;
        end
        else if (s1_h_reg >= SPAN_AT_2)
        begin
            s2_data_next.sector = SEC_G_TO_C;
            base                = SPAN_AT_2;
        end
        else if (s1_h_reg >= SPAN_AT_1)
        begin
            s2_data_next.sector = SEC_Y_TO_G;
            base                = SPAN_AT_1;
        end
        else
        begin
            s2_data_next.sector = SEC_R_TO_Y;
            base                = '0;
        end
        pos = RAMP_BITS'(s1_h_reg - base);
        s2_data_next.ramp   = s2_data_next.sector[0] ? (SPAN[RAMP_BITS-1:0] - pos) : pos;
        s2_data_next.chroma = s1_c_reg;
        s2_data_next.offset = s1_m_reg;
        s2_data_next.err    = s1_err_reg;
    end

    // Advance stage 2 valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Load stage 2 payload
    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_data_reg <= s2_data_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_data_reg;

    // A rejected item carries no color into the datapath
    `ASSERT_IMPL(a_err_black, clk, rst_n, s1_valid_reg && (s1_err_reg != ERR_NONE), (s1_c_reg == '0) && (s1_m_reg == '0) && (s1_h_reg == '0))
    // Chroma plus offset never exceeds full value
    `ASSERT_IMPL(a_cm_bound, clk, rst_n, s1_valid_reg, (18'(s1_c_reg) + 18'(s1_m_reg)) <= 18'd65536)
    // Sector and ramp stay in range
    `ASSERT_IMPL(a_sector_range, clk, rst_n, s2_valid_reg, (s2_data_reg.sector <= SEC_M_TO_R) && (s2_data_reg.ramp <= SPAN[RAMP_BITS-1:0]))
    // An item in stage 1 moves on when stage 2 can take it
    `ASSERT_NEXT(a_s1_moves, clk, rst_n, s1_valid_reg && s2_ready, s2_valid_reg)

endmodule

/* src/hsvc_mix.sv */
// ---------------------------------------------------------------------------
// hsvc_mix
// Stages 3 and 4: chroma times ramp, sector routing to channels, offset add
// and scaling to the channel range ahead of the divide by 15.
// ---------------------------------------------------------------------------
module hsvc_mix
    import hsvc_pkg::*;
#(
    parameter int CHANNEL_BITS = DEF_CHANNEL_BITS
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  hsvc_front_t                        in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [2:0][CHANNEL_BITS+3:0]       out_level,
    output logic [ERR_BITS-1:0]                out_err
);

    localparam int QW = CHANNEL_BITS + 4;
    localparam int NW = PROD_BITS + CHANNEL_BITS;

    // Stage 3 registers
    logic                  s3_valid_reg;
    logic [PROD_BITS-1:0]  s3_xw_reg, s3_xw_next;
    logic [PROD_BITS-1:0]  s3_cw_reg, s3_cw_next;
    logic [PROD_BITS-1:0]  s3_mw_reg, s3_mw_next;
    logic [2:0]            s3_sector_reg;
    logic [ERR_BITS-1:0]   s3_err_reg;
    logic                  s3_ready;

    // Stage 4 registers
    logic                  s4_valid_reg;
    logic [2:0][QW-1:0]    s4_level_reg, s4_level_next;
    logic [ERR_BITS-1:0]   s4_err_reg;
    logic                  s4_ready;

    logic [2:0][PROD_BITS-1:0] sel;
    logic [PROD_BITS-1:0]      sum;
    logic [NW-1:0]             scaled;

    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s4_ready = !s4_valid_reg || out_ready;
    assign in_ready = s3_ready;

    // Form the full, ramp and offset terms in 1/(65536 * SPAN)
    always_comb
    begin
        s3_xw_next = PROD_BITS'(in_data.chroma) * PROD_BITS'(in_data.ramp);
        s3_cw_next = PROD_BITS'(in_data.chroma) * PROD_BITS'(SPAN);
        s3_mw_next = PROD_BITS'(in_data.offset) * PROD_BITS'(SPAN);
    end

    // Advance stage 3 valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_ready)
        begin
            s3_valid_reg <= in_valid;
        end
    end

    // Load stage 3 payload
    always_ff @(posedge clk)
    begin
        if (s3_ready && in_valid)
        begin
            s3_xw_reg     <= s3_xw_next;
            s3_cw_reg     <= s3_cw_next;
            s3_mw_reg     <= s3_mw_next;
            s3_sector_reg <= in_data.sector;
            s3_err_reg    <= in_data.err;
        end
    end

    // Route terms to red, green, blue by sector; add offset; scale by
    // 2^CHANNEL_BITS - 1 and drop the 2^28 part of the divisor
    always_comb
    begin
        sel = '0;
        case (s3_sector_reg)
            SEC_R_TO_Y:
            begin
                sel[0] = s3_cw_reg;
                sel[1] = s3_xw_reg;
            end
            SEC_Y_TO_G:
            begin
                sel[0] = s3_xw_reg;
                sel[1] = s3_cw_reg;
            end
            SEC_G_TO_C:
            begin
                sel[1] = s3_cw_reg;
                sel[2] = s3_xw_reg;
            end
            SEC_C_TO_B:
            begin
                sel[1] = s3_xw_reg;
                sel[2] = s3_cw_reg;
            end
            SEC_B_TO_M:
            begin
                sel[0] = s3_xw_reg;
                sel[2] = s3_cw_reg;
            end
            default:
            begin
                sel[0] = s3_cw_reg;
                sel[2] = s3_xw_reg;
            end
        endcase
        for (int ch = 0; ch < 3; ch++)
        begin
            sum    = PROD_BITS'(sel[ch] + s3_mw_reg);
            scaled = (NW'(sum) << CHANNEL_BITS) - NW'(sum);
            s4_level_next[ch] = scaled[NW-1:LEVEL_SHIFT];
        end
    end

    // Advance stage 4 valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (s4_ready)
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // Load stage 4 payload
    always_ff @(posedge clk)
    begin
        if (s4_ready && s3_valid_reg)
        begin
            s4_level_reg <= s4_level_next;
            s4_err_reg   <= s3_err_reg;
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_level = s4_level_reg;
    assign out_err   = s4_err_reg;

endmodule

/* src/hsvc_div.sv */
// ---------------------------------------------------------------------------
// hsvc_div
// Stage 5: exact divide of each channel level by 15 through a reciprocal
// multiply; holds the output word.
// ---------------------------------------------------------------------------
module hsvc_div
    import hsvc_pkg::*;
#(
    parameter int CHANNEL_BITS = DEF_CHANNEL_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [2:0][CHANNEL_BITS+3:0]  in_level,
    input  logic [ERR_BITS-1:0]           in_err,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [CHANNEL_BITS-1:0]       red,
    output logic [CHANNEL_BITS-1:0]       green,
    output logic [CHANNEL_BITS-1:0]       blue,
    output logic [ERR_BITS-1:0]           error_code
);

    // floor(x * ceil(2^K / 15) / 2^K) equals floor(x / 15) for every x
    // below 2^QW when K = QW + 4
    localparam int QW = CHANNEL_BITS + 4;
    localparam int K  = QW + 4;
    localparam int MW = QW + 1;
    localparam int PW = QW + MW;
    localparam logic [MW-1:0] RECIP = MW'(((64'd1 << K) + 64'd14) / 64'd15);

    logic                                 s5_valid_reg;
    logic [2:0][CHANNEL_BITS-1:0]         s5_chan_reg, s5_chan_next;
    logic [ERR_BITS-1:0]                  s5_err_reg;
    logic                                 s5_ready;
    logic [PW-1:0]                        prod;

    assign s5_ready = !s5_valid_reg || out_ready;
    assign in_ready = s5_ready;

    // Divide each level by 15
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            prod = PW'(in_level[ch]) * PW'(RECIP);
            s5_chan_next[ch] = prod[K +: CHANNEL_BITS];
        end
    end

    // Advance output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
        end
        else if (s5_ready)
        begin
            s5_valid_reg <= in_valid;
        end
    end

    // Load output word
    always_ff @(posedge clk)
    begin
        if (s5_ready && in_valid)
        begin
            s5_chan_reg <= s5_chan_next;
            s5_err_reg  <= in_err;
        end
    end

    assign out_valid  = s5_valid_reg;
    assign red        = s5_chan_reg[0];
    assign green      = s5_chan_reg[1];
    assign blue       = s5_chan_reg[2];
    assign error_code = s5_err_reg;

endmodule

/* src/hsv_to_rgb_colormap_unit.sv */
// ---------------------------------------------------------------------------
// hsv_to_rgb_colormap_unit
// One pixel per word from HSV or a colormap scalar to RGB, fixed point.
// ---------------------------------------------------------------------------
// Usage:
//   s_tvalid/s_tready/s_tdata carry one input word per pixel: hue,
//   saturation, brightness and scale_value. m_tvalid/m_tready/m_tdata carry
//   one result word per pixel: red, green, blue and error_code.
//   cfg_valid/cfg_ready/cfg_data write color_mode (0 direct HSV, 1 red-green,
//   2 rainbow, 3 gray); cfg_ready is always high. Write it only while no
//   word is in flight.
//   m_tvalid rises once a word has passed all five register stages (decode,
//   sector, ramp multiply, channel scaling, divide by 15); the accept edge
//   loads the first. Throughput is one word per cycle while m_tready stays
//   high; each stage takes a new word whenever its successor moves on.
//   An out-of-range field gives a nonzero error_code and black color.
//   Reset clears all stage valid bits and sets color_mode to direct HSV.
//   When the receiver stalls the output word holds; empty stages upstream
//   keep filling, and s_tready drops once every stage holds a word.
// ---------------------------------------------------------------------------
module hsv_to_rgb_colormap_unit
    import hsvc_pkg::*;
#(
    parameter int CHANNEL_BITS  = DEF_CHANNEL_BITS,
    parameter int HUE_FRAC_BITS = DEF_HUE_FRAC_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // s_tdata, from bit 0: hue[15:0], saturation[8:0], brightness[8:0],
    // scale_value[10:0], zero pad
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_DATA_BITS-1:0] s_tdata,
    // m_tdata, from bit 0: red, green, blue (CHANNEL_BITS each),
    // error_code[2:0], zero pad
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [((3*CHANNEL_BITS+ERR_BITS+7)/8)*8-1:0] m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [MODE_BITS-1:0]   cfg_data
);

    localparam int OUT_BITS = ((3*CHANNEL_BITS + ERR_BITS + 7) / 8) * 8;
    localparam int RES_BITS = 3*CHANNEL_BITS + ERR_BITS;

    logic [MODE_BITS-1:0]          color_mode_reg;

    logic                          front_valid;
    logic                          front_ready;
    hsvc_front_t                   front_data;

    logic                          mix_valid;
    logic                          mix_ready;
    logic [2:0][CHANNEL_BITS+3:0]  mix_level;
    logic [ERR_BITS-1:0]           mix_err;

    logic [CHANNEL_BITS-1:0]       red;
    logic [CHANNEL_BITS-1:0]       green;
    logic [CHANNEL_BITS-1:0]       blue;
    logic [ERR_BITS-1:0]           error_code;

    // Hold the mode register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_mode_reg <= MODE_DIRECT;
        end
        else if (cfg_valid)
        begin
            color_mode_reg <= cfg_data;
        end
    end

    hsvc_front #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .hue         (s_tdata[15:0]),
        .saturation  (s_tdata[24:16]),
        .brightness  (s_tdata[33:25]),
        .scale_value (s_tdata[44:34]),
        .color_mode  (color_mode_reg),
        .out_valid   (front_valid),
        .out_ready   (front_ready),
        .out_data    (front_data)
    );

    hsvc_mix #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (mix_valid),
        .out_ready (mix_ready),
        .out_level (mix_level),
        .out_err   (mix_err)
    );

    hsvc_div #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (mix_valid),
        .in_ready   (mix_ready),
        .in_level   (mix_level),
        .in_err     (mix_err),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .error_code (error_code)
    );

    // Pack the result word, zero-padded to whole bytes
    assign m_tdata = OUT_BITS'(RES_BITS'({error_code, blue, green, red}));

endmodule

/* tb/hsv_to_rgb_colormap_unit_tb.sv */
// ---------------------------------------------------------------------------
// hsv_to_rgb_colormap_unit_tb
// Streams pixels through the colormap unit in every color mode and checks
// each result word against an RGB predictor kept in the testbench. Directed
// corner pixels come first, then random phases with idle gaps on both sides,
// a long receiver stall and drain pauses between mode changes.
// ---------------------------------------------------------------------------
module hsv_to_rgb_colormap_unit_tb;
    import hsvc_pkg::*;

    localparam int              CH_BITS       = DEF_CHANNEL_BITS;
    localparam int              OUT_BITS      = ((3 * CH_BITS + ERR_BITS + 7) / 8) * 8;
    localparam longint unsigned CH_MAX        = (64'd1 << CH_BITS) - 1;
    localparam longint unsigned HUE_Q         = 64'd1 << DEF_HUE_FRAC_BITS;
    localparam longint unsigned SV_UNIT       = 256;
    localparam longint unsigned SCALE_UNIT    = 64'd1 << SCALE_FRAC_BITS;
    localparam longint unsigned HUE_LIMIT     = 360 * HUE_Q;
    localparam int              PHASE_COUNT   = 8;
    localparam int              PHASE_ITEMS   = 240;
    localparam int              IDLE_PERCENT  = 22;
    localparam int              SINK_HOLD     = 80;
    localparam int              DRAIN_SLACK   = 8;
    localparam int              LIMIT_CYCLES  = 200000;

    typedef struct packed {
        logic [CH_BITS-1:0]  red;
        logic [CH_BITS-1:0]  green;
        logic [CH_BITS-1:0]  blue;
        logic [ERR_BITS-1:0] err;
    } rgb_word_t;

    // -----------------------------------------------------------------------
    // Predicts RGB words for accepted pixels and checks result words in order
    // -----------------------------------------------------------------------
    class rgb_scoreboard;
        logic [MODE_BITS-1:0] color_mode;
        rgb_word_t            expected_rgb[$];
        int                   mismatch_count;

        function new();
            color_mode     = MODE_DIRECT;
            mismatch_count = 0;
        endfunction

        function void set_mode(input logic [MODE_BITS-1:0] mode);
            color_mode = mode;
        endfunction

        function int pending();
            return expected_rgb.size();
        endfunction

        // Scale a sum in 1/(65536 * span) to a truncated channel level
        function logic [CH_BITS-1:0] channel_level(input longint unsigned n,
                                                   input longint unsigned span);
            return CH_BITS'(((CH_MAX * n) / (64'd65536 * span)) & CH_MAX);
        endfunction

        // Six-sector mix; h in 1/q degree, s and v in 1/256
        function rgb_word_t hsv_mix(input longint unsigned h, input longint unsigned q,
                                    input longint unsigned s, input longint unsigned v);
            longint unsigned span, sector, pos, chroma, offset, ramp;
            longint unsigned cw, xw, mw, rr, gg, bb;
            rgb_word_t       w;
            span   = 60 * q;
            sector = h / span;
            pos    = h % span;
            chroma = v * s;
            offset = v * SV_UNIT - chroma;
            ramp   = sector[0] ? (span - pos) : pos;
            cw     = chroma * span;
            xw     = chroma * ramp;
            mw     = offset * span;
            case (sector)
                SEC_R_TO_Y: begin rr = cw; gg = xw; bb = 0;  end
                SEC_Y_TO_G: begin rr = xw; gg = cw; bb = 0;  end
                SEC_G_TO_C: begin rr = 0;  gg = cw; bb = xw; end
                SEC_C_TO_B: begin rr = 0;  gg = xw; bb = cw; end
                SEC_B_TO_M: begin rr = xw; gg = 0;  bb = cw; end
                default:    begin rr = cw; gg = 0;  bb = xw; end
            endcase
            w.red   = channel_level(rr + mw, span);
            w.green = channel_level(gg + mw, span);
            w.blue  = channel_level(bb + mw, span);
            w.err   = ERR_NONE;
            return w;
        endfunction

        function rgb_word_t predict_rgb(input logic [HUE_BITS-1:0] hue,
                                        input logic [SV_BITS-1:0] sat,
                                        input logic [SV_BITS-1:0] bri,
                                        input logic [SCALE_BITS-1:0] scale);
            rgb_word_t       w;
            longint unsigned gray;
            w = '0;
            if (color_mode == MODE_DIRECT) begin
                // saturation beats value beats hue
                if (sat > SV_UNIT)
                    w.err = ERR_SAT;
                else if (bri > SV_UNIT)
                    w.err = ERR_VAL;
                else if (hue >= HUE_LIMIT)
                    w.err = ERR_HUE;
                else
                    w = hsv_mix(hue, HUE_Q, sat, bri);
            end
            else if (scale > SCALE_UNIT)
                w.err = ERR_SCALE;
            else if (color_mode == MODE_RED_GREEN)
                w = hsv_mix(longint'(scale) * 120, SCALE_UNIT, SV_UNIT, SV_UNIT);
            else if (color_mode == MODE_RAINBOW)
                w = hsv_mix(longint'(scale) * 270, SCALE_UNIT, SV_UNIT, SV_UNIT);
            else begin
                gray    = ((CH_MAX * scale) / SCALE_UNIT) & CH_MAX;
                w.red   = CH_BITS'(gray);
                w.green = CH_BITS'(gray);
                w.blue  = CH_BITS'(gray);
            end
            return w;
        endfunction

        function void note_pixel(input logic [HUE_BITS-1:0] hue,
                                 input logic [SV_BITS-1:0] sat,
                                 input logic [SV_BITS-1:0] bri,
                                 input logic [SCALE_BITS-1:0] scale);
            expected_rgb.push_back(predict_rgb(hue, sat, bri, scale));
        endfunction

        task report(input string what, input int got, input int want);
            $display("rgb mismatch: %s got %0d expected %0d (mode %0d)",
                     what, got, want, color_mode);
            mismatch_count++;
        endtask

        task check_pixel(input logic [OUT_BITS-1:0] data);
            rgb_word_t got, want;
            got.red   = data[CH_BITS-1:0];
            got.green = data[2*CH_BITS-1:CH_BITS];
            got.blue  = data[3*CH_BITS-1:2*CH_BITS];
            got.err   = data[3*CH_BITS+ERR_BITS-1:3*CH_BITS];
            if (expected_rgb.size() == 0) begin
                report("unexpected word", int'(data), 0);
                return;
            end
            want = expected_rgb.pop_front();
            if (got.red !== want.red)
                report("red", got.red, want.red);
            if (got.green !== want.green)
                report("green", got.green, want.green);
            if (got.blue !== want.blue)
                report("blue", got.blue, want.blue);
            if (got.err !== want.err)
                report("error_code", got.err, want.err);
        endtask
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_DATA_BITS-1:0] s_tdata;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_BITS-1:0]     m_tdata;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [MODE_BITS-1:0]    cfg_data;

    rgb_scoreboard sb;
    bit            idle_enabled = 1'b1;
    bit            hold_request = 1'b0;
    int            cycle_count  = 0;

    hsv_to_rgb_colormap_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("hsv_to_rgb_colormap_unit_tb: done, errors");
            $finish;
        end
    end

    // Accept result words; stall at random or for a long hold when asked
    initial
    begin : result_sink
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_pixel(m_tdata);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (SINK_HOLD) @(posedge clk);
            end
            m_tready <= !(idle_enabled && $urandom_range(99) < IDLE_PERCENT);
        end
    end

    // Offer one input word and return at the edge that accepts it
    task automatic send_pixel(input logic [HUE_BITS-1:0] hue,
                              input logic [SV_BITS-1:0] sat,
                              input logic [SV_BITS-1:0] bri,
                              input logic [SCALE_BITS-1:0] scale);
        while (idle_enabled && $urandom_range(99) < IDLE_PERCENT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_BITS - HUE_BITS - 2*SV_BITS - SCALE_BITS){1'b0}},
                     scale, bri, sat, hue};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_pixel(hue, sat, bri, scale);
    endtask

    // Drop valid and wait for every expected word to come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    // Change color mode with the pipeline empty
    task automatic write_mode(input logic [MODE_BITS-1:0] mode);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_mode(mode);
    endtask

    // Mostly well-formed pixels, some with every field at random
    task automatic send_random_pixel();
        logic [HUE_BITS-1:0]   hue;
        logic [SV_BITS-1:0]    sat;
        logic [SV_BITS-1:0]    bri;
        logic [SCALE_BITS-1:0] scale;
        int                    pick;
        pick  = $urandom_range(99);
        hue   = HUE_BITS'($urandom);
        sat   = SV_BITS'($urandom);
        bri   = SV_BITS'($urandom);
        scale = SCALE_BITS'($urandom);
        if (pick < 80)
        begin
            hue   = HUE_BITS'($urandom_range(HUE_LIMIT - 1));
            sat   = SV_BITS'($urandom_range(SV_UNIT));
            bri   = SV_BITS'($urandom_range(SV_UNIT));
            scale = SCALE_BITS'($urandom_range(SCALE_UNIT));
        end
        else if (pick < 88)
        begin
            // edge values of the valid ranges
            hue   = $urandom_range(1) ? HUE_BITS'(HUE_LIMIT - 1) : '0;
            sat   = $urandom_range(1) ? SV_BITS'(SV_UNIT) : '0;
            bri   = $urandom_range(1) ? SV_BITS'(SV_UNIT) : '0;
            scale = $urandom_range(1) ? SCALE_BITS'(SCALE_UNIT) : '0;
        end
        send_pixel(hue, sat, bri, scale);
    endtask

    initial
    begin : stimulus
        logic [MODE_BITS-1:0] phase_mode [PHASE_COUNT];
        phase_mode = '{MODE_DIRECT, MODE_RED_GREEN, MODE_RAINBOW, MODE_GRAY,
                       MODE_DIRECT, MODE_GRAY, MODE_RAINBOW, MODE_DIRECT};
        sb = new();
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= MODE_DIRECT;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Direct mode: sector starts, hue limits, error precedence, gray, black
        write_mode(MODE_DIRECT);
        send_pixel(16'd0,     9'd256, 9'd256, 11'd0);
        send_pixel(16'd3840,  9'd256, 9'd256, 11'd2047);
        send_pixel(16'd7680,  9'd256, 9'd256, 11'd0);
        send_pixel(16'd11520, 9'd256, 9'd256, 11'd0);
        send_pixel(16'd15360, 9'd200, 9'd180, 11'd0);
        send_pixel(16'd19200, 9'd128, 9'd256, 11'd0);
        send_pixel(16'd23039, 9'd256, 9'd256, 11'd0);
        send_pixel(16'd23040, 9'd256, 9'd256, 11'd0);
        send_pixel(16'hFFFF,  9'd511, 9'd511, 11'd0);
        send_pixel(16'd100,   9'd257, 9'd0,   11'd0);
        send_pixel(16'hFFFF,  9'd256, 9'd257, 11'd0);
        send_pixel(16'd12345, 9'd0,   9'd256, 11'd0);
        send_pixel(16'd1920,  9'd256, 9'd0,   11'd0);

        // Colormap modes: scalar ends, out of range, ignored hsv fields
        write_mode(MODE_RED_GREEN);
        send_pixel(16'd0,     9'd0,   9'd0,   11'd0);
        send_pixel(16'd0,     9'd0,   9'd0,   11'd1024);
        send_pixel(16'd0,     9'd0,   9'd0,   11'd1025);
        write_mode(MODE_RAINBOW);
        send_pixel(16'd0,     9'd0,   9'd0,   11'd1024);
        send_pixel(16'hFFFF,  9'd511, 9'd511, 11'd512);
        send_pixel(16'd0,     9'd0,   9'd0,   11'd2047);
        write_mode(MODE_GRAY);
        send_pixel(16'd0,     9'd0,   9'd0,   11'd0);
        send_pixel(16'd0,     9'd0,   9'd0,   11'd1);
        send_pixel(16'd0,     9'd0,   9'd0,   11'd1024);
        send_pixel(16'd0,     9'd0,   9'd0,   11'd1025);

        // Random phases, one color mode each
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            write_mode(phase_mode[phase]);
            idle_enabled = (phase != 2);
            if (phase == 3)
                hold_request = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (phase == 5 && i == PHASE_ITEMS / 2)
                    wait_drained();
                send_random_pixel();
            end
        end
        idle_enabled = 1'b1;
        wait_drained();

        if (sb.mismatch_count == 0 && sb.pending() == 0)
            $display("hsv_to_rgb_colormap_unit_tb: done, clean");
        else
            $display("hsv_to_rgb_colormap_unit_tb: done, errors");
        $finish;
    end

endmodule
